// ===== sv/line_follower_pid_controller_core_defines.svh =====
// Assertion macros for the line follower controller state machine.
`ifndef LINE_FOLLOWER_PID_CONTROLLER_CORE_DEFINES_SVH
`define LINE_FOLLOWER_PID_CONTROLLER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define LFPC_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define LFPC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// ===== sv/lfpc_pkg.sv =====
// Shared types and constants of the line follower controller.
package lfpc_pkg;
	localparam int SAMPLE_BITS = 10;
	localparam int NSENS = 5;
	localparam int NORM_FULL = 1000;
	localparam int ON_LINE_LEVEL = 700;
	localparam int MOTOR_MAX = 80;
	localparam int RECOVER_SPEED = 150;
	localparam int CAL_SPEED = 70;
	localparam int THICK_LIMIT = 22;
	localparam int ERR_W = 13;
	localparam int SUM_W = 24;
	localparam logic [1:0] CMD_CAL_START = 2'd0;
	localparam logic [1:0] CMD_CAL_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_FOLLOW = 2'd2;
	localparam logic [2:0] REG_DARK = 3'd0;
	localparam logic [2:0] REG_THICK = 3'd1;
	localparam logic [2:0] REG_BRAKE = 3'd2;
	localparam logic [2:0] REG_GP = 3'd3;
	localparam logic [2:0] REG_GI = 3'd4;
	localparam logic [2:0] REG_GD = 3'd5;
	localparam logic [2:0] REG_CRUISE = 3'd6;

	typedef struct packed {
		logic dark_line;
		logic [5:0] line_thickness;
		logic brake_enabled;
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [7:0] cruise_speed;
	} cfg_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // capture the input beat
		logic calib;      // apply calibration update
		logic div_start;  // start normalizing sensor sel
		logic [2:0] sel;
		logic norm_store; // store quotient of sensor sel
		logic err_calc;
		logic mul_step;   // one PID product, index sel
		logic finish;     // form result and update state
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	typedef struct packed {
		logic [7:0] left_speed;
		logic left_reverse;
		logic [7:0] right_speed;
		logic right_reverse;
		logic brake_first;
		logic on_line;
		logic signed [15:0] correction;
	} res_t;
endpackage

// ===== sv/lfpc_if.sv =====
// Valid/ready channel interfaces for items, results and register writes.
interface lfpc_in_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [9:0] sample_far_left;
	logic [9:0] sample_left;
	logic [9:0] sample_middle;
	logic [9:0] sample_right;
	logic [9:0] sample_far_right;
	modport source(output valid, cmd, sample_far_left, sample_left, sample_middle,
		sample_right, sample_far_right, input ready);
	modport sink(input valid, cmd, sample_far_left, sample_left, sample_middle,
		sample_right, sample_far_right, output ready);
endinterface

interface lfpc_out_if;
	logic valid;
	logic ready;
	logic [7:0] left_speed;
	logic left_reverse;
	logic [7:0] right_speed;
	logic right_reverse;
	logic brake_first;
	logic on_line;
	logic signed [15:0] correction;
	modport source(output valid, left_speed, left_reverse, right_speed, right_reverse,
		brake_first, on_line, correction, input ready);
	modport sink(input valid, left_speed, left_reverse, right_speed, right_reverse,
		brake_first, on_line, correction, output ready);
endinterface

interface lfpc_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/lfpc_div.sv =====
// Restoring divider: 20-bit dividend by 13-bit divisor, one quotient bit a cycle.
module lfpc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [19:0] dividend,
	input  logic [12:0] divisor,
	output logic        done,
	output logic [19:0] quotient
);
	logic [4:0] cnt_q;
	logic busy_q;
	logic [19:0] quo_q;
	logic [13:0] rem_q;
	logic [12:0] dsr_q;
	logic [14:0] trial;

	assign trial = {rem_q, quo_q[19]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd19) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[14]) begin
				rem_q <= trial[13:0];
				quo_q <= {quo_q[18:0], 1'b1};
			end else begin
				rem_q <= {rem_q[12:0], quo_q[19]};
				quo_q <= {quo_q[18:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// ===== sv/lfpc_datapath.sv =====
// Datapath: calibration store, normalizing, PID arithmetic and motor result.
module lfpc_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  lfpc_pkg::cmd_t   cmd,
	output lfpc_pkg::sts_t   sts,
	input  lfpc_pkg::cfg_t   cfg,
	input  logic [1:0]       in_cmd,
	input  logic [9:0]       in_s [lfpc_pkg::NSENS],
	output lfpc_pkg::res_t   res
);
	localparam int SAMPLE_BITS = lfpc_pkg::SAMPLE_BITS;

	logic [SAMPLE_BITS-1:0] smp_q [lfpc_pkg::NSENS];
	logic [SAMPLE_BITS-1:0] min_q [lfpc_pkg::NSENS];
	logic [SAMPLE_BITS-1:0] max_q [lfpc_pkg::NSENS];
	logic [10:0] v_q [lfpc_pkg::NSENS];
	logic [1:0] icmd_q;
	logic signed [lfpc_pkg::ERR_W-1:0] last_err_q, err_q;
	logic signed [lfpc_pkg::SUM_W-1:0] sum_q;
	logic signed [42:0] acc_q;
	logic [7:0] speed_q;
	logic lost_q;
	logic seen_q;

	// Normalizing operands for the selected sensor.
	logic [SAMPLE_BITS-1:0] s_sel, lo_sel, hi_sel;
	logic [SAMPLE_BITS-1:0] dif_mag, rng_mag;
	logic [19:0] dvd;
	logic [12:0] dvs;
	logic [19:0] quo;
	logic range_zero, below, neg_range;

	always_comb begin
		s_sel = smp_q[0]; lo_sel = min_q[0]; hi_sel = max_q[0];
		for (int i = 0; i < lfpc_pkg::NSENS; i++) begin
			if (cmd.sel == 3'(i)) begin
				s_sel = smp_q[i]; lo_sel = min_q[i]; hi_sel = max_q[i];
			end
		end
	end
	assign range_zero = (hi_sel == lo_sel);
	assign below = (s_sel < lo_sel);
	assign neg_range = (hi_sel < lo_sel);
	// The divider works on magnitudes; the two signs decide between zero and the quotient.
	assign dif_mag = below ? (lo_sel - s_sel) : (s_sel - lo_sel);
	assign rng_mag = neg_range ? (lo_sel - hi_sel) : (hi_sel - lo_sel);
	assign dvd = 20'(dif_mag) * 20'(lfpc_pkg::NORM_FULL);
	assign dvs = 13'(rng_mag);

	lfpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dvd), .divisor(dvs), .done(sts.div_done), .quotient(quo)
	);

	// A negative quotient clamps to zero, a large one to the full value.
	logic [10:0] v_new;
	always_comb begin
		if (range_zero) v_new = 11'd0;
		else if (below != neg_range) v_new = 11'd0;
		else if (quo > 20'(lfpc_pkg::NORM_FULL)) v_new = 11'(lfpc_pkg::NORM_FULL);
		else v_new = quo[10:0];
	end

	logic on_sel;
	assign on_sel = cfg.dark_line ? (v_new > 11'(lfpc_pkg::ON_LINE_LEVEL))
		: (v_new < 11'(lfpc_pkg::ON_LINE_LEVEL));

	// Error and PID terms.
	logic signed [15:0] e_raw;
	logic signed [lfpc_pkg::ERR_W-1:0] e_fix;
	logic signed [lfpc_pkg::SUM_W+1:0] sum_wide;
	logic signed [lfpc_pkg::SUM_W-1:0] sum_sat;
	always_comb begin
		e_raw = 16'sd3 * $signed({5'd0, v_q[0]}) + $signed({5'd0, v_q[1]})
			- $signed({5'd0, v_q[3]}) - 16'sd3 * $signed({5'd0, v_q[4]});
		if ((cfg.line_thickness > 6'(lfpc_pkg::THICK_LIMIT)) ^ cfg.dark_line) e_raw = -e_raw;
		e_fix = e_raw[lfpc_pkg::ERR_W-1:0];
		sum_wide = 26'(sum_q) + 26'(e_fix);
		if (sum_wide > 26'sd8388607) sum_sat = 24'sd8388607;
		else if (sum_wide < -26'sd8388608) sum_sat = -24'sd8388608;
		else sum_sat = sum_wide[23:0];
	end

	logic signed [24:0] m_a;
	logic signed [16:0] m_b;
	logic signed [41:0] prod;
	always_comb begin
		m_b = $signed({1'b0, cfg.gain_p});
		m_a = 25'(err_q);
		case (cmd.sel)
			3'd1: begin m_b = $signed({1'b0, cfg.gain_i}); m_a = 25'(sum_q); end
			3'd2: begin
				m_b = $signed({1'b0, cfg.gain_d});
				m_a = 25'(err_q) - 25'(last_err_q);
			end
			default: ;
		endcase
		prod = m_a * m_b;
	end

	// The motor mix uses the speed after this step's ramp.
	logic signed [42:0] acc_t;
	logic signed [34:0] q256;
	logic signed [15:0] corr;
	logic signed [15:0] corr_lim;
	logic [7:0] speed_nxt;
	logic signed [10:0] lm, rm;
	logic [7:0] lsp, rsp;
	always_comb begin
		acc_t = acc_q + ((acc_q < 0) ? 43'sd255 : 43'sd0);
		q256 = acc_t[42:8];
		if (q256 > 35'sd32767) corr = 16'sd32767;
		else if (q256 < -35'sd32768) corr = -16'sd32768;
		else corr = q256[15:0];
		speed_nxt = (speed_q < cfg.cruise_speed) ? speed_q + 8'd1 : speed_q;
		corr_lim = corr > 16'sd500 ? 16'sd500 : corr < -16'sd500 ? -16'sd500 : corr;
		lm = $signed({3'b000, speed_nxt}) - 11'(corr_lim);
		rm = $signed({3'b000, speed_nxt}) + 11'(corr_lim);
		lsp = lm < 0 ? 8'd0 : lm > 11'sd80 ? 8'(lfpc_pkg::MOTOR_MAX) : lm[7:0];
		rsp = rm < 0 ? 8'd0 : rm > 11'sd80 ? 8'(lfpc_pkg::MOTOR_MAX) : rm[7:0];
	end

	lfpc_pkg::res_t res_nxt;
	always_comb begin
		res_nxt = '0;
		if (icmd_q == lfpc_pkg::CMD_CAL_START || icmd_q == lfpc_pkg::CMD_CAL_SAMPLE) begin
			res_nxt.left_speed = 8'(lfpc_pkg::CAL_SPEED);
			res_nxt.right_speed = 8'(lfpc_pkg::CAL_SPEED);
			res_nxt.right_reverse = 1'b1;
		end else if (icmd_q == lfpc_pkg::CMD_FOLLOW) begin
			if (seen_q) begin
				res_nxt.left_speed = lsp; res_nxt.right_speed = rsp;
				res_nxt.on_line = 1'b1; res_nxt.correction = corr;
			end else begin
				res_nxt.left_speed = 8'(lfpc_pkg::RECOVER_SPEED);
				res_nxt.right_speed = 8'(lfpc_pkg::RECOVER_SPEED);
				res_nxt.left_reverse = (last_err_q > 0);
				res_nxt.right_reverse = !(last_err_q > 0);
				res_nxt.brake_first = cfg.brake_enabled && !lost_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lfpc_pkg::NSENS; i++) begin
				min_q[i] <= '0; max_q[i] <= '0;
			end
			last_err_q <= '0; sum_q <= '0; speed_q <= 8'd60; lost_q <= 1'b0;
			seen_q <= 1'b0;
		end else begin
			if (cmd.calib) begin
				for (int i = 0; i < lfpc_pkg::NSENS; i++) begin
					if (icmd_q == lfpc_pkg::CMD_CAL_START) begin
						min_q[i] <= smp_q[i]; max_q[i] <= smp_q[i];
					end else begin
						if (smp_q[i] < min_q[i]) min_q[i] <= smp_q[i];
						if (smp_q[i] > max_q[i]) max_q[i] <= smp_q[i];
					end
				end
			end
			if (cmd.load) seen_q <= 1'b0;
			if (cmd.norm_store && on_sel) seen_q <= 1'b1;
			if (cmd.err_calc && seen_q) sum_q <= sum_sat;
			if (cmd.finish && icmd_q == lfpc_pkg::CMD_FOLLOW) begin
				speed_q <= speed_nxt;
				if (seen_q) begin
					last_err_q <= err_q; lost_q <= 1'b0;
				end else lost_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			icmd_q <= in_cmd;
			for (int i = 0; i < lfpc_pkg::NSENS; i++) smp_q[i] <= in_s[i][SAMPLE_BITS-1:0];
		end
		if (cmd.norm_store)
			for (int i = 0; i < lfpc_pkg::NSENS; i++)
				if (cmd.sel == 3'(i)) v_q[i] <= v_new;
		if (cmd.err_calc) begin
			err_q <= e_fix; acc_q <= '0;
		end
		if (cmd.mul_step) acc_q <= acc_q + 43'(prod);
		if (cmd.finish) res <= res_nxt;
	end
endmodule

// ===== sv/lfpc_ctrl.sv =====
// Controller state machine sequencing one item through the datapath.
`include "line_follower_pid_controller_core_defines.svh"
module lfpc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output lfpc_pkg::cmd_t cmd,
	input  lfpc_pkg::sts_t sts
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001, S_DECIDE = 7'b0000010, S_DIV = 7'b0000100,
		S_ERR = 7'b0001000, S_MUL = 7'b0010000, S_FIN = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;
	state_t state_q;
	logic [2:0] sel_q;
	logic [1:0] icmd_q;
	logic started_q;

	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		cmd.load = (state_q == S_IDLE) && in_valid;
		unique case (state_q)
			S_DECIDE: cmd.calib = (icmd_q == lfpc_pkg::CMD_CAL_START)
				|| (icmd_q == lfpc_pkg::CMD_CAL_SAMPLE);
			S_DIV: begin
				cmd.div_start = !started_q;
				cmd.norm_store = sts.div_done;
			end
			S_ERR: cmd.err_calc = 1'b1;
			S_MUL: cmd.mul_step = 1'b1;
			S_FIN: cmd.finish = 1'b1;
			default: ;
		endcase
	end
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; sel_q <= '0; icmd_q <= '0; started_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					icmd_q <= in_cmd; state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					sel_q <= '0; started_q <= 1'b0;
					state_q <= (icmd_q == lfpc_pkg::CMD_FOLLOW) ? S_DIV : S_FIN;
				end
				S_DIV: begin
					started_q <= 1'b1;
					if (sts.div_done) begin
						started_q <= 1'b0;
						if (sel_q == 3'(lfpc_pkg::NSENS - 1)) begin
							sel_q <= '0; state_q <= S_ERR;
						end else sel_q <= sel_q + 3'd1;
					end
				end
				S_ERR: state_q <= S_MUL;
				S_MUL: if (sel_q == 3'd2) begin
					sel_q <= '0; state_q <= S_FIN;
				end else sel_q <= sel_q + 3'd1;
				S_FIN: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`LFPC_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !out_valid)
	`LFPC_ASSERT_NEXT(a_fin_out, clk, arst_n, cmd.finish, out_valid)
	`LFPC_ASSERT_IMP(a_sel_range, clk, arst_n, state_q == S_DIV, sel_q < 3'(lfpc_pkg::NSENS))
endmodule

// ===== sv/line_follower_pid_controller_core.sv =====
// Calibration and undefined items pass S_DECIDE and S_FIN before the result is valid.
// Follow items also pass S_DIV, with five normalizing divisions on one divider, S_ERR and S_MUL.
// One item at a time: the next beat is taken only once the result beat leaves, and
// config writes are always accepted.
// Reset: asynchronous arst_n restores register defaults, clears calibration limits,
// error history and lost state, and sets the current speed to 60.
module line_follower_pid_controller_core (
	input logic clk,
	input logic arst_n,
	lfpc_in_if.sink in_ch,
	lfpc_out_if.source out_ch,
	lfpc_cfg_if.sink cfg_ch
);
	lfpc_pkg::cfg_t cfg_q;
	lfpc_pkg::cmd_t cmd;
	lfpc_pkg::sts_t sts;
	lfpc_pkg::res_t res;
	logic [9:0] smp [lfpc_pkg::NSENS];

	// Register writes are taken in any cycle.
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{dark_line: 1'b1, line_thickness: 6'd25, brake_enabled: 1'b0,
				gain_p: 16'd31, gain_i: 16'd0, gain_d: 16'd384, cruise_speed: 8'd60};
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				lfpc_pkg::REG_DARK: cfg_q.dark_line <= cfg_ch.data[0];
				lfpc_pkg::REG_THICK: cfg_q.line_thickness <= cfg_ch.data[5:0];
				lfpc_pkg::REG_BRAKE: cfg_q.brake_enabled <= cfg_ch.data[0];
				lfpc_pkg::REG_GP: cfg_q.gain_p <= cfg_ch.data;
				lfpc_pkg::REG_GI: cfg_q.gain_i <= cfg_ch.data;
				lfpc_pkg::REG_GD: cfg_q.gain_d <= cfg_ch.data;
				lfpc_pkg::REG_CRUISE: cfg_q.cruise_speed <= cfg_ch.data[7:0];
				default: ;
			endcase
		end
	end

	assign smp[0] = in_ch.sample_far_left;
	assign smp[1] = in_ch.sample_left;
	assign smp[2] = in_ch.sample_middle;
	assign smp[3] = in_ch.sample_right;
	assign smp[4] = in_ch.sample_far_right;

	// The controller sequences each beat; the datapath does all arithmetic.
	lfpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_cmd(in_ch.cmd), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	lfpc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .cfg(cfg_q),
		.in_cmd(in_ch.cmd), .in_s(smp), .res(res)
	);

	// Result fields are held in the datapath until the result beat is taken.
	assign out_ch.left_speed = res.left_speed;
	assign out_ch.left_reverse = res.left_reverse;
	assign out_ch.right_speed = res.right_speed;
	assign out_ch.right_reverse = res.right_reverse;
	assign out_ch.brake_first = res.brake_first;
	assign out_ch.on_line = res.on_line;
	assign out_ch.correction = res.correction;
endmodule

// ===== tb/line_follower_pid_controller_core_tb.sv =====
// Self-checking testbench for the five-sensor PID line follower core.
module line_follower_pid_controller_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The package names the three defined commands; the fourth code is undefined.
	localparam logic [1:0] CMD_UNDEF = 2'd3;
	// Longer than any item takes, so this covers any item still in flight.
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 500;
	localparam int NPHASES = 6;

	logic clk;
	logic arst_n;

	lfpc_in_if in_ch();
	lfpc_out_if out_ch();
	lfpc_cfg_if cfg_ch();

	line_follower_pid_controller_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always #1 clk = ~clk;

	// Shadow copy of the controller registers and of its internal state.
	lfpc_pkg::cfg_t cfg_shadow;
	logic [9:0] cal_min [lfpc_pkg::NSENS];
	logic [9:0] cal_max [lfpc_pkg::NSENS];
	int prev_error;
	int integ_sum;
	int ramp_speed;
	bit line_lost;

	lfpc_pkg::res_t motor_cmds_due [$];
	int mismatches = 0;
	int cycles = 0;
	int burst_left;

	typedef struct {
		logic [1:0] cmd;
		logic [9:0] s [lfpc_pkg::NSENS];
		bit typed;
		lfpc_pkg::res_t want;
	} stim_row_t;

	function automatic void reset_shadow();
		cfg_shadow.dark_line = 1'b1;
		cfg_shadow.line_thickness = 6'd25;
		cfg_shadow.brake_enabled = 1'b0;
		cfg_shadow.gain_p = 16'd31;
		cfg_shadow.gain_i = 16'd0;
		cfg_shadow.gain_d = 16'd384;
		cfg_shadow.cruise_speed = 8'd60;
		for (int i = 0; i < lfpc_pkg::NSENS; i++) begin
			cal_min[i] = '0;
			cal_max[i] = '0;
		end
		prev_error = 0;
		integ_sum = 0;
		ramp_speed = 60;
		line_lost = 1'b0;
	endfunction

	// Scale a raw sample to 0..1000 against the calibrated span of its sensor.
	function automatic int scale_sample(logic [9:0] s, logic [9:0] lo, logic [9:0] hi);
		int span;
		int v;
		span = int'(hi) - int'(lo);
		if (span == 0) return 0;
		v = ((int'(s) - int'(lo)) * lfpc_pkg::NORM_FULL) / span;
		if (v < 0) v = 0;
		if (v > lfpc_pkg::NORM_FULL) v = lfpc_pkg::NORM_FULL;
		return v;
	endfunction

	function automatic int clip_motor(longint v);
		if (v < 0) return 0;
		if (v > lfpc_pkg::MOTOR_MAX) return lfpc_pkg::MOTOR_MAX;
		return int'(v);
	endfunction

	// Advance the shadow state by one item and return the motor command it yields.
	function automatic lfpc_pkg::res_t predict_motor_cmd(logic [1:0] cmd,
		logic [9:0] s [lfpc_pkg::NSENS]);
		lfpc_pkg::res_t r;
		int v [lfpc_pkg::NSENS];
		bit seen;
		int err;
		longint sum;
		longint acc;
		longint corr;
		r = '0;
		seen = 1'b0;
		if (cmd == lfpc_pkg::CMD_CAL_START || cmd == lfpc_pkg::CMD_CAL_SAMPLE) begin
			for (int i = 0; i < lfpc_pkg::NSENS; i++) begin
				if (cmd == lfpc_pkg::CMD_CAL_START) begin
					cal_min[i] = s[i];
					cal_max[i] = s[i];
				end else begin
					if (s[i] < cal_min[i]) cal_min[i] = s[i];
					if (s[i] > cal_max[i]) cal_max[i] = s[i];
				end
			end
			r.left_speed = 8'(lfpc_pkg::CAL_SPEED);
			r.right_speed = 8'(lfpc_pkg::CAL_SPEED);
			r.right_reverse = 1'b1;
			return r;
		end
		if (cmd == CMD_UNDEF) return r;
		for (int i = 0; i < lfpc_pkg::NSENS; i++) begin
			v[i] = scale_sample(s[i], cal_min[i], cal_max[i]);
			if ((cfg_shadow.dark_line && v[i] > lfpc_pkg::ON_LINE_LEVEL) ||
				(!cfg_shadow.dark_line && v[i] < lfpc_pkg::ON_LINE_LEVEL)) seen = 1'b1;
		end
		if (ramp_speed < int'(cfg_shadow.cruise_speed)) ramp_speed = (ramp_speed + 1) & 8'hFF;
		if (seen) begin
			err = 3 * v[0] + v[1] - v[3] - 3 * v[4];
			if (cfg_shadow.line_thickness > lfpc_pkg::THICK_LIMIT) err = -err;
			if (cfg_shadow.dark_line) err = -err;
			sum = longint'(integ_sum) + err;
			if (sum > 8388607) sum = 8388607;
			if (sum < -8388608) sum = -8388608;
			integ_sum = int'(sum);
			acc = longint'(cfg_shadow.gain_p) * err + longint'(cfg_shadow.gain_i) * integ_sum
				+ longint'(cfg_shadow.gain_d) * longint'(err - prev_error);
			corr = acc / 256;
			if (corr > 32767) corr = 32767;
			if (corr < -32768) corr = -32768;
			prev_error = err;
			line_lost = 1'b0;
			r.left_speed = 8'(clip_motor(longint'(ramp_speed) - corr));
			r.right_speed = 8'(clip_motor(longint'(ramp_speed) + corr));
			r.on_line = 1'b1;
			r.correction = corr[15:0];
		end else begin
			r.left_speed = 8'(lfpc_pkg::RECOVER_SPEED);
			r.right_speed = 8'(lfpc_pkg::RECOVER_SPEED);
			r.left_reverse = (prev_error > 0);
			r.right_reverse = !(prev_error > 0);
			r.brake_first = cfg_shadow.brake_enabled && !line_lost;
			line_lost = 1'b1;
		end
		return r;
	endfunction

	// Present one item and hold it until the core takes the beat. Valid stays high
	// afterwards within a burst so back-to-back items never toggle it within one step.
	task automatic send_item(logic [1:0] cmd, logic [9:0] s [lfpc_pkg::NSENS], bit typed,
		lfpc_pkg::res_t want);
		lfpc_pkg::res_t predicted;
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.sample_far_left <= s[0];
		in_ch.sample_left <= s[1];
		in_ch.sample_middle <= s[2];
		in_ch.sample_right <= s[3];
		in_ch.sample_far_right <= s[4];
		do @(posedge clk); while (!in_ch.ready);
		predicted = predict_motor_cmd(cmd, s);
		motor_cmds_due.push_back(typed ? want : predicted);
		// The sender works in bursts; between most of them valid is dropped.
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		while (motor_cmds_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			lfpc_pkg::REG_DARK: cfg_shadow.dark_line = data[0];
			lfpc_pkg::REG_THICK: cfg_shadow.line_thickness = data[5:0];
			lfpc_pkg::REG_BRAKE: cfg_shadow.brake_enabled = data[0];
			lfpc_pkg::REG_GP: cfg_shadow.gain_p = data;
			lfpc_pkg::REG_GI: cfg_shadow.gain_i = data;
			lfpc_pkg::REG_GD: cfg_shadow.gain_d = data;
			lfpc_pkg::REG_CRUISE: cfg_shadow.cruise_speed = data[7:0];
			default: ;
		endcase
	endtask

	// Pick a follow sample: mostly inside the calibrated span so the line is
	// found and the PID runs, sometimes at the rails or anywhere at all.
	function automatic logic [9:0] follow_sample(int i);
		int lo;
		int hi;
		lo = int'(cal_min[i]);
		hi = int'(cal_max[i]);
		case ($urandom_range(0, 9))
			0: return 10'd0;
			1: return 10'h3FF;
			2, 3: return 10'($urandom_range(0, 1023));
			default: return 10'($urandom_range(lo, hi));
		endcase
	endfunction

	// Receiver: ready follows a randomly redrawn pattern, ranging
	// from no stalls at all through random stalls to long stall stretches.
	int ready_mode;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			ready_mode <= 0;
		end else begin
			if (cycles % 50 == 0) ready_mode <= $urandom_range(0, 2);
			case (ready_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Each motor command beat is checked against the oldest outstanding one.
	always @(posedge clk) begin
		lfpc_pkg::res_t got;
		lfpc_pkg::res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.left_speed = out_ch.left_speed;
			got.left_reverse = out_ch.left_reverse;
			got.right_speed = out_ch.right_speed;
			got.right_reverse = out_ch.right_reverse;
			got.brake_first = out_ch.brake_first;
			got.on_line = out_ch.on_line;
			got.correction = out_ch.correction;
			if (motor_cmds_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected motor beat at cycle %0d", cycles);
			end else begin
				want = motor_cmds_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch cycle %0d: exp L%0d/%0b R%0d/%0b brk%0b on%0b c%0d",
							cycles, want.left_speed, want.left_reverse, want.right_speed,
							want.right_reverse, want.brake_first, want.on_line,
							want.correction);
						$display("  got L%0d/%0b R%0d/%0b brk%0b on%0b c%0d",
							got.left_speed, got.left_reverse, got.right_speed,
							got.right_reverse, got.brake_first, got.on_line, got.correction);
					end
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Register settings per phase, in register index order. The first phase keeps
	// the reset values; the others hit the gain, speed and thickness extremes.
	logic [15:0] phase_regs [NPHASES][7] = '{
		'{16'd1, 16'd25, 16'd0, 16'd31, 16'd0, 16'd384, 16'd60},
		'{16'd0, 16'd10, 16'd1, 16'd256, 16'd16, 16'd128, 16'd80},
		'{16'd1, 16'd35, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255},
		'{16'd0, 16'd22, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd1, 16'd23, 16'd1, 16'd600, 16'd3, 16'd900, 16'd40},
		'{16'd0, 16'd63, 16'd1, 16'd100, 16'd1, 16'd2000, 16'd255}
	};

	stim_row_t directed [$];

	task automatic add_row(logic [1:0] cmd, logic [9:0] a, logic [9:0] b, logic [9:0] c,
		logic [9:0] d, logic [9:0] e, bit typed, lfpc_pkg::res_t want);
		stim_row_t row;
		row.cmd = cmd;
		row.s[0] = a;
		row.s[1] = b;
		row.s[2] = c;
		row.s[3] = d;
		row.s[4] = e;
		row.typed = typed;
		row.want = want;
		directed.push_back(row);
	endtask

	initial begin
		lfpc_pkg::res_t cal_cmd;
		lfpc_pkg::res_t lost_cmd;
		lfpc_pkg::res_t none;
		logic [9:0] s [lfpc_pkg::NSENS];
		logic [1:0] cmd;
		int sent;
		int n_cal;
		int n_follow;

		clk = 1'b0;
		arst_n = 1'b0;
		burst_left = 4;
		in_ch.valid = 1'b0;
		in_ch.cmd = lfpc_pkg::CMD_CAL_START;
		in_ch.sample_far_left = '0;
		in_ch.sample_left = '0;
		in_ch.sample_middle = '0;
		in_ch.sample_right = '0;
		in_ch.sample_far_right = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = lfpc_pkg::REG_DARK;
		cfg_ch.data = '0;
		reset_shadow();

		none = '0;
		cal_cmd = '0;
		cal_cmd.left_speed = 8'(lfpc_pkg::CAL_SPEED);
		cal_cmd.right_speed = 8'(lfpc_pkg::CAL_SPEED);
		cal_cmd.right_reverse = 1'b1;
		lost_cmd = '0;
		lost_cmd.left_speed = 8'(lfpc_pkg::RECOVER_SPEED);
		lost_cmd.right_speed = 8'(lfpc_pkg::RECOVER_SPEED);
		lost_cmd.right_reverse = 1'b1;

		// Directed part. Straight after reset every span is empty, so a follow item
		// scales to zero everywhere and the robot spins with no error history.
		add_row(lfpc_pkg::CMD_FOLLOW, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1, lost_cmd);
		add_row(CMD_UNDEF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1, none);
		add_row(CMD_UNDEF, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1, none);
		add_row(lfpc_pkg::CMD_CAL_START, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1, cal_cmd);
		add_row(lfpc_pkg::CMD_CAL_SAMPLE, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1,
			cal_cmd);
		add_row(lfpc_pkg::CMD_FOLLOW, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 0, none);
		add_row(lfpc_pkg::CMD_FOLLOW, 10'h3FF, 10'd0, 10'd0, 10'd0, 10'd0, 0, none);
		add_row(lfpc_pkg::CMD_FOLLOW, 10'd0, 10'd0, 10'd0, 10'h3FF, 10'h3FF, 0, none);
		add_row(lfpc_pkg::CMD_FOLLOW, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 0, none);
		add_row(lfpc_pkg::CMD_FOLLOW, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 0, none);
		// Right at the on-line level: 717 scales to exactly 700, 718 just above it.
		add_row(lfpc_pkg::CMD_FOLLOW, 10'd0, 10'd0, 10'd717, 10'd0, 10'd0, 0, none);
		add_row(lfpc_pkg::CMD_FOLLOW, 10'd0, 10'd0, 10'd718, 10'd0, 10'd0, 0, none);
		add_row(lfpc_pkg::CMD_FOLLOW, 10'h2AA, 10'h155, 10'd0, 10'h155, 10'h2AA, 0, none);
		// A calibration start with one value gives a zero span on every sensor.
		add_row(lfpc_pkg::CMD_CAL_START, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 1,
			cal_cmd);
		add_row(lfpc_pkg::CMD_FOLLOW, 10'd512, 10'h3FF, 10'd0, 10'd511, 10'd513, 0, none);
		add_row(lfpc_pkg::CMD_CAL_SAMPLE, 10'd100, 10'd900, 10'd0, 10'h3FF, 10'd300, 1,
			cal_cmd);
		add_row(lfpc_pkg::CMD_FOLLOW, 10'd50, 10'd950, 10'd1000, 10'd600, 10'd400, 0, none);
		add_row(lfpc_pkg::CMD_FOLLOW, 10'd512, 10'd700, 10'd20, 10'd1020, 10'd512, 0, none);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_item(directed[i].cmd, directed[i].s, directed[i].typed,
			directed[i].want);

		sent = 0;
		for (int ph = 0; ph < NPHASES; ph++) begin
			// Registers change only with the core idle: the sender holds off until
			// every outstanding motor command has come back.
			in_ch.valid <= 1'b0;
			wait_drained();
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (ph > 0) begin
				for (int r = 0; r < 7; r++) write_reg(3'(r), phase_regs[ph][r]);
				cfg_ch.valid <= 1'b0;
			end
			while (sent < (RANDOM_ITEMS * (ph + 1)) / NPHASES) begin
				if ($urandom_range(0, 3) != 0) begin
					// A well-formed run: calibrate, widen, then follow.
					for (int i = 0; i < lfpc_pkg::NSENS; i++) s[i] = 10'($urandom_range(0, 1023));
					send_item(lfpc_pkg::CMD_CAL_START, s, 0, none);
					n_cal = $urandom_range(1, 5);
					for (int k = 0; k < n_cal; k++) begin
						for (int i = 0; i < lfpc_pkg::NSENS; i++)
							s[i] = 10'($urandom_range(0, 1023));
						send_item(lfpc_pkg::CMD_CAL_SAMPLE, s, 0, none);
					end
					n_follow = $urandom_range(4, 20);
					for (int k = 0; k < n_follow; k++) begin
						for (int i = 0; i < lfpc_pkg::NSENS; i++) s[i] = follow_sample(i);
						send_item(lfpc_pkg::CMD_FOLLOW, s, 0, none);
					end
					sent += 1 + n_cal + n_follow;
				end else begin
					// Noise: any command with arbitrary samples.
					cmd = 2'($urandom_range(0, 3));
					for (int i = 0; i < lfpc_pkg::NSENS; i++) s[i] = 10'($urandom_range(0, 1023));
					send_item(cmd, s, 0, none);
					sent++;
				end
			end
		end

		in_ch.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && motor_cmds_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
